// ===== rtl/pakc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the peer address key cache.
package pakc_pkg;

    localparam int NUM_PEERS = 4;
    localparam int SLOT_W    = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
    localparam int KEY_W     = 8;
    localparam int QPN_W     = 32;
    localparam int GID_W     = 64;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_STORE  = 1'b1;

    localparam logic [KEY_W-1:0]  KEY_RESET  = KEY_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(1 % NUM_PEERS);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(NUM_PEERS - 1);
    localparam logic [KEY_W-1:0]  KEY_LAST   = {KEY_W{1'b1}};

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] lookup_key;
        logic [QPN_W-1:0] peer_qpn;
        logic [GID_W-1:0] gid_upper;
        logic [GID_W-1:0] gid_lower;
    } req_t;

    typedef struct packed {
        logic             matched;
        logic [KEY_W-1:0] result_key;
        logic [QPN_W-1:0] result_qpn;
        logic [GID_W-1:0] result_gid_upper;
        logic [GID_W-1:0] result_gid_lower;
    } rsp_t;

endpackage

// ===== rtl/peer_address_key_cache_unit.sv =====
`timescale 1ns / 1ps
// Top level of the peer address key cache: request and result registers.
//
// Usage:
//   A request transfer happens at a rising edge with start high and busy
//   low. busy is always low, so a request may be issued every cycle.
//   req.mode selects a lookup (address by key) or a store (key by address).
//   Every request gives exactly one result. done is high for one cycle and
//   the result fields on rsp are valid in that cycle; the result transfer
//   happens at the edge that ends it. There is no back pressure on the
//   result side, so the receiver must take each result as it comes.
// Timing: the request is captured in the request register, then the result
//   is loaded into the result register and done rises with it. Throughput: one
//   request per cycle; the table match, key allocation and entry update all
//   complete combinationally between the request and result registers.
// Reset: rst_n (async, active low) clears all entries to key 0 and an
//   all-zero address, sets the next key to 1 and drops done.
module peer_address_key_cache_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  pakc_pkg::req_t req,
    output logic           done,
    output pakc_pkg::rsp_t rsp
);
    import pakc_pkg::*;

    req_t req_reg;
    logic valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic done_reg;

    // single-pass pipeline never stalls
    assign busy = 1'b0;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= req;
    end

    // match and update; the table updates at the same edge the result is
    // registered, so the next request sees the new contents
    pakc_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (valid_reg),
        .req   (req_reg),
        .rsp   (rsp_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
            rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg == $past(valid_reg))
        else $error("result strobe out of step with request");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && req_reg.mode == MODE_LOOKUP && !rsp_next.matched
        |=> rsp_reg.result_key == '0 && rsp_reg.result_qpn == '0)
        else $error("lookup miss returned nonzero fields");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> valid_reg)
        else $error("request dropped");

endmodule

// ===== rtl/pakc_table.sv =====
`timescale 1ns / 1ps
// Entry storage, parallel match, key allocation and round-robin update.
module pakc_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  pakc_pkg::req_t req,
    output pakc_pkg::rsp_t rsp
);
    import pakc_pkg::*;

    logic [KEY_W-1:0]  entry_key_reg [NUM_PEERS];
    logic [QPN_W-1:0]  entry_qpn_reg [NUM_PEERS];
    logic [GID_W-1:0]  entry_ghi_reg [NUM_PEERS];
    logic [GID_W-1:0]  entry_glo_reg [NUM_PEERS];
    logic [KEY_W-1:0]  next_key_reg;
    logic [KEY_W-1:0]  next_key_next;
    // tracks next_key mod NUM_PEERS without a divider
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    logic              any_hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              alloc;

    // first match in index order: scan downward so the lowest index wins
    always_comb
    begin
        any_hit  = 1'b0;
        hit_slot = '0;
        for (int i = NUM_PEERS - 1; i >= 0; i--)
        begin
            if (req.mode == MODE_LOOKUP)
            begin
                if (entry_key_reg[i] == req.lookup_key)
                begin
                    any_hit  = 1'b1;
                    hit_slot = SLOT_W'(i);
                end
            end
            else
            begin
                if (entry_qpn_reg[i] == req.peer_qpn &&
                    entry_ghi_reg[i] == req.gid_upper &&
                    entry_glo_reg[i] == req.gid_lower)
                begin
                    any_hit  = 1'b1;
                    hit_slot = SLOT_W'(i);
                end
            end
        end
    end

    assign alloc = fire && (req.mode == MODE_STORE) && !any_hit;

    always_comb
    begin
        next_key_next = next_key_reg + KEY_W'(1);
        if (next_key_reg == KEY_LAST || slot_reg == SLOT_LAST)
            slot_next = '0;
        else
            slot_next = slot_reg + SLOT_W'(1);
    end

    always_comb
    begin
        if (any_hit)
        begin
            rsp.matched          = 1'b1;
            rsp.result_key       = entry_key_reg[hit_slot];
            rsp.result_qpn       = entry_qpn_reg[hit_slot];
            rsp.result_gid_upper = entry_ghi_reg[hit_slot];
            rsp.result_gid_lower = entry_glo_reg[hit_slot];
        end
        else if (req.mode == MODE_STORE)
        begin
            rsp.matched          = 1'b0;
            rsp.result_key       = next_key_reg;
            rsp.result_qpn       = req.peer_qpn;
            rsp.result_gid_upper = req.gid_upper;
            rsp.result_gid_lower = req.gid_lower;
        end
        else
        begin
            rsp = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_key_reg <= KEY_RESET;
            slot_reg     <= SLOT_RESET;
            for (int i = 0; i < NUM_PEERS; i++)
            begin
                entry_key_reg[i] <= '0;
                entry_qpn_reg[i] <= '0;
                entry_ghi_reg[i] <= '0;
                entry_glo_reg[i] <= '0;
            end
        end
        else if (alloc)
        begin
            next_key_reg <= next_key_next;
            slot_reg     <= slot_next;
            for (int i = 0; i < NUM_PEERS; i++)
            begin
                if (slot_reg == SLOT_W'(i))
                begin
                    entry_key_reg[i] <= next_key_reg;
                    entry_qpn_reg[i] <= req.peer_qpn;
                    entry_ghi_reg[i] <= req.gid_upper;
                    entry_glo_reg[i] <= req.gid_lower;
                end
            end
        end
    end

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < NUM_PEERS)
        else $error("slot pointer out of range");

    a_lookup_keeps_key: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.mode == MODE_LOOKUP |=> $stable(next_key_reg))
        else $error("lookup changed the key counter");

    a_store_hit_keeps_key: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.mode == MODE_STORE && any_hit |=> $stable(next_key_reg))
        else $error("store hit changed the key counter");

    a_alloc_advances: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |=> next_key_reg == $past(next_key_reg) + KEY_W'(1))
        else $error("allocation did not advance the key counter");

endmodule

// ===== tb/tb_peer_address_key_cache_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the peer address key cache: directed and random requests.
module tb_peer_address_key_cache_unit;

    import pakc_pkg::*;

    localparam int ADDR_W      = QPN_W + 2 * GID_W;
    localparam int RAND_ITEMS  = 430;
    // new addresses; with evictions and near misses the key counter wraps
    localparam int MIN_FRESH   = 220;
    localparam int POOL_SIZE   = 8;
    localparam int DRAIN_CYC   = 4;
    localparam int CYCLE_LIMIT = 50000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    peer_address_key_cache_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #2 clk = ~clk;

    // Shadow copy of the table and the key counter.
    logic [KEY_W-1:0] shadow_key    [NUM_PEERS];
    logic [QPN_W-1:0] shadow_qpn    [NUM_PEERS];
    logic [GID_W-1:0] shadow_gid_hi [NUM_PEERS];
    logic [GID_W-1:0] shadow_gid_lo [NUM_PEERS];
    logic [KEY_W-1:0] shadow_next_key;

    req_t pending_req_q[$];
    rsp_t expected_rsp_q[$];

    int   cycle_cnt     = 0;
    int   items_total   = 0;
    int   items_sent    = 0;
    int   items_taken   = 0;
    int   error_cnt     = 0;
    int   lookup_hits   = 0;
    int   lookup_misses = 0;
    int   store_hits    = 0;
    int   store_allocs  = 0;
    int   key0_allocs   = 0;
    logic xfer_seen     = 1'b0;

    // Predict the response to one request and update the shadow table.
    // Scanning from the top index down leaves the lowest matching index.
    function automatic rsp_t cache_respond(req_t r);
        rsp_t             o;
        logic             hit;
        int               pick;
        int               slot;
        logic [KEY_W-1:0] k;
        hit  = 1'b0;
        pick = 0;
        if (r.mode == MODE_LOOKUP)
        begin
            for (int i = NUM_PEERS - 1; i >= 0; i--)
                if (shadow_key[i] == r.lookup_key)
                begin
                    hit  = 1'b1;
                    pick = i;
                end
            if (!hit)
                return '0;
        end
        else
        begin
            for (int i = NUM_PEERS - 1; i >= 0; i--)
                if (shadow_qpn[i] == r.peer_qpn && shadow_gid_hi[i] == r.gid_upper &&
                    shadow_gid_lo[i] == r.gid_lower)
                begin
                    hit  = 1'b1;
                    pick = i;
                end
            if (!hit)
            begin
                // Miss: hand out the next key, overwrite slot key mod table size.
                k               = shadow_next_key;
                shadow_next_key = shadow_next_key + 1'b1;
                slot            = int'(k) % NUM_PEERS;
                shadow_key[slot]    = k;
                shadow_qpn[slot]    = r.peer_qpn;
                shadow_gid_hi[slot] = r.gid_upper;
                shadow_gid_lo[slot] = r.gid_lower;
                pick            = slot;
            end
        end
        o.matched          = hit;
        o.result_key       = shadow_key[pick];
        o.result_qpn       = shadow_qpn[pick];
        o.result_gid_upper = shadow_gid_hi[pick];
        o.result_gid_lower = shadow_gid_lo[pick];
        return o;
    endfunction

    task automatic check_rsp(rsp_t want, rsp_t got);
        if (got.matched !== want.matched)
        begin
            $display("%0t: matched mismatch: expected %0b actual %0b",
                     $time, want.matched, got.matched);
            error_cnt++;
        end
        if (got.result_key !== want.result_key)
        begin
            $display("%0t: result_key mismatch: expected %02h actual %02h",
                     $time, want.result_key, got.result_key);
            error_cnt++;
        end
        if (got.result_qpn !== want.result_qpn)
        begin
            $display("%0t: result_qpn mismatch: expected %08h actual %08h",
                     $time, want.result_qpn, got.result_qpn);
            error_cnt++;
        end
        if (got.result_gid_upper !== want.result_gid_upper)
        begin
            $display("%0t: result_gid_upper mismatch: expected %016h actual %016h",
                     $time, want.result_gid_upper, got.result_gid_upper);
            error_cnt++;
        end
        if (got.result_gid_lower !== want.result_gid_lower)
        begin
            $display("%0t: result_gid_lower mismatch: expected %016h actual %016h",
                     $time, want.result_gid_lower, got.result_gid_lower);
            error_cnt++;
        end
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // Unused operand fields carry random values: the block must ignore them.
    function automatic req_t make_store(logic [ADDR_W-1:0] a);
        req_t r;
        r.mode       = MODE_STORE;
        r.lookup_key = KEY_W'($urandom());
        {r.peer_qpn, r.gid_upper, r.gid_lower} = a;
        return r;
    endfunction

    function automatic req_t make_lookup(logic [KEY_W-1:0] k);
        req_t r;
        r.mode       = MODE_LOOKUP;
        r.lookup_key = k;
        {r.peer_qpn, r.gid_upper, r.gid_lower} = rand_addr();
        return r;
    endfunction

    // Monitor: check results first, then predict the request transferred at this edge.
    // A result always trails its request through the request and result registers, so the order is safe.
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        cycle_cnt++;
        xfer_seen = rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none actual %h", $time, rsp);
                error_cnt++;
            end
            else
            begin
                check_rsp(expected_rsp_q.pop_front(), rsp);
            end
        end
        if (xfer_seen)
        begin
            exp_rsp = cache_respond(req);
            expected_rsp_q.push_back(exp_rsp);
            items_taken++;
            if (req.mode == MODE_LOOKUP)
            begin
                if (exp_rsp.matched) lookup_hits++;
                else                 lookup_misses++;
            end
            else if (exp_rsp.matched)
            begin
                store_hits++;
            end
            else
            begin
                store_allocs++;
                if (exp_rsp.result_key == '0) key0_allocs++;
            end
        end
    end

    // Driver: a held request stays put until transferred; otherwise pick the next
    // one or idle about 38 times in 100, except for a stretch with no gaps at all.
    always @(negedge clk)
    begin
        logic steady;
        logic gap;
        if (rst_n && !(start && !xfer_seen))
        begin
            steady = (items_sent >= 150) && (items_sent < 260);
            gap    = !steady && ($urandom_range(99) < 38);
            if (pending_req_q.size() != 0 && !gap)
            begin
                req   <= pending_req_q.pop_front();
                start <= 1'b1;
                items_sent++;
            end
            else
            begin
                req   <= make_store(rand_addr());
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_rsp_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] pool [POOL_SIZE];
        logic [ADDR_W-1:0] a;
        logic [KEY_W-1:0]  last_key;
        int                n_rand;
        int                fresh;
        int                pool_wr;
        int                pick;

        for (int i = 0; i < NUM_PEERS; i++)
        begin
            shadow_key[i]    = '0;
            shadow_qpn[i]    = '0;
            shadow_gid_hi[i] = '0;
            shadow_gid_lo[i] = '0;
        end
        shadow_next_key = KEY_RESET;
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = rand_addr();

        // Directed: empty entries take part in matching, extremes, eviction.
        pending_req_q.push_back(make_lookup(8'h00));          // hits an empty entry
        pending_req_q.push_back(make_lookup(8'h01));          // miss, all-zero result
        pending_req_q.push_back(make_lookup(KEY_LAST));       // miss
        pending_req_q.push_back(make_store('0));              // zero address hits empty entry
        pending_req_q.push_back(make_store('1));              // new entry, key 1
        pending_req_q.push_back(make_store('1));              // hit, counter holds
        pending_req_q.push_back(make_lookup(8'h01));
        pending_req_q.push_back(make_store({ADDR_W{1'b1}} ^ (ADDR_W'(1) << (2 * GID_W))));
        pending_req_q.push_back(make_store(pool[0]));
        pending_req_q.push_back(make_store(pool[1]));         // evicts slot 0
        pending_req_q.push_back(make_lookup(8'h00));          // empty entry gone
        pending_req_q.push_back(make_store('0));              // zero address now a miss
        pending_req_q.push_back(make_lookup(8'h05));
        pending_req_q.push_back(make_store('1));              // evicted earlier, reallocated
        pending_req_q.push_back(make_store({{QPN_W{1'b0}}, {GID_W{1'b1}}, {GID_W{1'b0}}}));
        pending_req_q.push_back(make_store({{QPN_W{1'b0}}, {GID_W{1'b0}}, {GID_W{1'b1}}}));
        pending_req_q.push_back(make_lookup(8'h08));
        pending_req_q.push_back(make_lookup(8'h04));          // evicted key
        pending_req_q.push_back(make_store(pool[1]));         // evicted by key 8, a miss, new entry
        last_key = 8'h08;

        // Random: mostly fresh stores so the counter wraps and hands out key 0,
        // with repeats, near misses and lookups of recently issued keys.
        n_rand  = 0;
        fresh   = 0;
        pool_wr = 2;
        while (n_rand < RAND_ITEMS || fresh < MIN_FRESH)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                a = rand_addr();
                pool[pool_wr] = a;
                pool_wr = (pool_wr + 1) % POOL_SIZE;
                pending_req_q.push_back(make_store(a));
                last_key++;
                fresh++;
            end
            else if (pick < 62)
            begin
                pending_req_q.push_back(make_store(pool[$urandom_range(POOL_SIZE - 1)]));
            end
            else if (pick < 67)
            begin
                // One bit off a known address: must not hit it.
                a = pool[$urandom_range(POOL_SIZE - 1)];
                a[$urandom_range(ADDR_W - 1)] ^= 1'b1;
                pending_req_q.push_back(make_store(a));
                last_key++;
            end
            else if (pick < 70)
            begin
                pending_req_q.push_back(make_store('0));
            end
            else if (pick < 95)
            begin
                pending_req_q.push_back(make_lookup(last_key - KEY_W'($urandom_range(6))));
            end
            else
            begin
                pending_req_q.push_back(make_lookup(KEY_W'($urandom())));
            end
            n_rand++;
        end
        items_total = pending_req_q.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_taken < items_total) @(posedge clk);
        while (expected_rsp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Covered %0d requests: lookups %0d hit / %0d miss, stores %0d hit / %0d new",
                 items_taken, lookup_hits, lookup_misses, store_hits, store_allocs);
        $display("Key 0 handed out after counter wrap %0d times; %0d field errors",
                 key0_allocs, error_cnt);
        if (error_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
